FILE: design/lrukv_pkg.sv
// package for the lru key-value cache
// holds action codes, register defaults and the per-cell control struct
// no dependencies
`default_nettype none

package lrukv_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int ACTION_W   = 3;
  localparam int MAX_SIZE_W = 5;
  localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 5'd16;

  localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

  typedef struct packed {
    logic take_prev;
    logic take_next;
    logic drop;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: design/lrukv_cell.sv
// one entry of the recency-ordered chain: valid, key and value
// loads from its more recent or less recent neighbor; uses lrukv_pkg
`default_nettype none

module lrukv_cell #(
  parameter int KEY_WIDTH   = lrukv_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = lrukv_pkg::VALUE_WIDTH_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  lrukv_pkg::cell_ctl_t  ctl,
  input  wire                         prev_valid,
  input  wire       [KEY_WIDTH-1:0]   prev_key,
  input  wire       [VALUE_WIDTH-1:0] prev_value,
  input  wire                         next_valid,
  input  wire       [KEY_WIDTH-1:0]   next_key,
  input  wire       [VALUE_WIDTH-1:0] next_value,
  input  wire       [KEY_WIDTH-1:0]   lookup_key,
  output logic                        valid,
  output logic      [KEY_WIDTH-1:0]   key,
  output logic      [VALUE_WIDTH-1:0] value,
  output logic                        match
);

  logic                   valid_next;
  logic [KEY_WIDTH-1:0]   key_next;
  logic [VALUE_WIDTH-1:0] value_next;

  assign match = valid && (key == lookup_key);

  always_comb begin
    valid_next = valid;
    key_next   = key;
    value_next = value;
    if (ctl.take_prev) begin
      valid_next = prev_valid;
      key_next   = prev_key;
      value_next = prev_value;
    end else if (ctl.take_next) begin
      valid_next = next_valid;
      key_next   = next_key;
      value_next = next_value;
    end
    if (ctl.drop) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    value <= value_next;
  end

endmodule

`default_nettype wire

FILE: design/lru_key_value_cache_core.sv
// top level of the lru key-value cache: handshake, request register and chain control
// instantiates lrukv_cell; uses lrukv_pkg
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement. Entries
// live in a chain of cells kept in recency order: cell 0 is the most recent and the
// valid entries always fill the front of the chain. At the accepting edge every cell
// compares its key with the request key and the match vector is registered; once the
// output register is free or read, the chain moves in one step (promote or insert
// shifts toward the tail, remove closes the gap, inserts trim everything at or past
// max_size) and the result is written to the output register. A result waiting on
// m_tready holds the update back; s_tready is low until the update. The user must write
// max_size through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.

module lru_key_value_cache_core #(
  parameter int CAPACITY    = lrukv_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH   = lrukv_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = lrukv_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = $clog2(CAPACITY + 1),
  parameter int IN_TDATA_W  =
    ((lrukv_pkg::ACTION_W + KEY_WIDTH + 2 * VALUE_WIDTH + 7) / 8) * 8,
  parameter int OUT_TDATA_W = ((1 + VALUE_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_wr_en,
  input  wire  [lrukv_pkg::MAX_SIZE_W-1:0]    cfg_wr_data,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // action, key, write_value, default_value
  input  wire  [IN_TDATA_W-1:0]               s_tdata,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // hit, read_value, entry_count
  output logic [OUT_TDATA_W-1:0]              m_tdata
);

  import lrukv_pkg::*;

  localparam int CMP_W     = (CNT_W > MAX_SIZE_W) ? CNT_W : MAX_SIZE_W;
  localparam int KEY_LSB   = ACTION_W;
  localparam int WV_LSB    = KEY_LSB + KEY_WIDTH;
  localparam int DV_LSB    = WV_LSB + VALUE_WIDTH;

  logic [MAX_SIZE_W-1:0]  max_size;
  logic [CNT_W-1:0]       count;
  logic                   pending;
  logic [ACTION_W-1:0]    req_action;
  logic [KEY_WIDTH-1:0]   req_key;
  logic [VALUE_WIDTH-1:0] req_wv;
  logic [VALUE_WIDTH-1:0] req_dv;
  logic [CAPACITY-1:0]    match_q;

  logic                   accept;
  logic                   upd;
  logic [KEY_WIDTH-1:0]   in_key;
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    ge_match;
  logic [CAPACITY-1:0]    le_match;
  logic                   hit;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [VALUE_WIDTH-1:0] front_value;
  logic [CMP_W-1:0]       limit_cmp;
  logic [CNT_W-1:0]       limit;
  logic [CNT_W-1:0]       cnt_plus;
  logic [CNT_W-1:0]       cnt_ins;
  logic [CNT_W-1:0]       count_next;
  logic                   hit_out;
  logic [VALUE_WIDTH-1:0] read_value;

  cell_ctl_t              ctl        [CAPACITY];
  logic                   cell_valid [CAPACITY];
  logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic                   prev_valid [CAPACITY];
  logic [KEY_WIDTH-1:0]   prev_key   [CAPACITY];
  logic [VALUE_WIDTH-1:0] prev_value [CAPACITY];
  logic                   next_valid [CAPACITY];
  logic [KEY_WIDTH-1:0]   next_key   [CAPACITY];
  logic [VALUE_WIDTH-1:0] next_value [CAPACITY];

  assign s_tready = !pending;
  assign accept   = s_tvalid && s_tready;
  assign upd      = pending && (!m_tvalid || m_tready);
  assign in_key   = s_tdata[KEY_LSB +: KEY_WIDTH];

  // chain neighbors: the head takes the request entry, the tail sees an empty slot
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        prev_valid[i] = 1'b1;
        prev_key[i]   = req_key;
        prev_value[i] = front_value;
      end else begin
        prev_valid[i] = cell_valid[i-1];
        prev_key[i]   = cell_key[i-1];
        prev_value[i] = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin
        next_valid[i] = 1'b0;
        next_key[i]   = '0;
        next_value[i] = '0;
      end else begin
        next_valid[i] = cell_valid[i+1];
        next_key[i]   = cell_key[i+1];
        next_value[i] = cell_value[i+1];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lrukv_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[g]),
      .prev_valid (prev_valid[g]),
      .prev_key   (prev_key[g]),
      .prev_value (prev_value[g]),
      .next_valid (next_valid[g]),
      .next_key   (next_key[g]),
      .next_value (next_value[g]),
      .lookup_key (in_key),
      .valid      (cell_valid[g]),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .match      (match[g])
    );
  end

  // match position masks and the matched value
  always_comb begin
    hit       = |match_q;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ge_match[i] = |(match_q >> i);
      le_match[i] = |(match_q << (CAPACITY - 1 - i));
      if (match_q[i]) begin
        hit_value = hit_value | cell_value[i];
      end
    end
    front_value = (req_action == ACT_INSERT) ? req_wv : hit_value;
  end

  // effective size limit
  always_comb begin
    if (CMP_W'(max_size) > CMP_W'(CAPACITY)) begin
      limit_cmp = CMP_W'(CAPACITY);
    end else begin
      limit_cmp = CMP_W'(max_size);
    end
    limit = limit_cmp[CNT_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i] = '0;
      if (upd) begin
        case (req_action)
          ACT_INSERT: begin
            ctl[i].take_prev = hit ? ge_match[i] : 1'b1;
            ctl[i].drop      = CMP_W'(i) >= limit_cmp;
          end
          ACT_LOOKUP: begin
            ctl[i].take_prev = hit && ge_match[i];
          end
          ACT_REMOVE: begin
            ctl[i].take_next = hit && le_match[i];
          end
          ACT_CLEAR: begin
            ctl[i].drop = 1'b1;
          end
          default: begin
            ctl[i] = '0;
          end
        endcase
      end
    end
  end

  // occupancy and result fields
  always_comb begin
    cnt_plus   = (count == CNT_W'(CAPACITY)) ? count : count + CNT_W'(1);
    cnt_ins    = hit ? count : cnt_plus;
    count_next = count;
    hit_out    = 1'b0;
    read_value = '0;
    case (req_action)
      ACT_INSERT: begin
        count_next = (cnt_ins > limit) ? limit : cnt_ins;
        hit_out    = hit;
      end
      ACT_LOOKUP: begin
        hit_out    = hit;
        read_value = hit ? hit_value : req_dv;
      end
      ACT_CONTAINS: begin
        hit_out = hit;
      end
      ACT_REMOVE: begin
        hit_out    = hit;
        count_next = hit ? count - CNT_W'(1) : count;
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= MAX_SIZE_RESET;
      count    <= '0;
      pending  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_size <= cfg_wr_data;
      end
      if (accept) begin
        pending <= 1'b1;
      end else if (upd) begin
        pending <= 1'b0;
      end
      if (upd) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= s_tdata[ACTION_W-1:0];
      req_key    <= in_key;
      req_wv     <= s_tdata[WV_LSB +: VALUE_WIDTH];
      req_dv     <= s_tdata[DV_LSB +: VALUE_WIDTH];
      match_q    <= match;
    end
    if (upd) begin
      m_tdata <= OUT_TDATA_W'({count_next, read_value, hit_out});
    end
  end

endmodule

`default_nettype wire
